@@ design/rme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// Shared constants, tables and cell data types for the Euler angle block.
// ----------------------------------------------------------------------------
package rme_pkg;

   localparam int CORDIC_STAGES = 28;
   localparam int SQRT_CELLS    = 32;
   localparam int CW            = 36;   // cordic datapath width
   localparam int SW            = 64;   // square root datapath width

   // bank/yaw results wait this long for the square root chain
   localparam int BANK_DELAY = SQRT_CELLS + 1;
   // registers from the first stage to the result register
   localparam int OUT_IDX    = CORDIC_STAGES + SQRT_CELLS + 4;

   localparam logic signed [31:0] UNIT_Q30 = 32'sd1073741824;
   localparam logic [30:0] GT_RESET        = 31'd1073731087;
   localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [CW-1:0] PI_Q28      = 36'sd843314857;
   localparam logic signed [30:0]   HALF_PI_Q28 = 31'sd421657428;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 zero;
      logic                 tag;
   } cordic_vec_type;

   typedef struct packed {
      logic [SW-1:0]      n;
      logic [SW-1:0]      res;
      logic signed [31:0] s;
   } sqrt_vec_type;

endpackage

@@ design/rme_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module rme_cordic_cell (
   input  logic                    clock,
   input  logic                    en,
   input  logic [4:0]              stage_idx,
   input  rme_pkg::cordic_vec_type vec_in,
   output rme_pkg::cordic_vec_type vec_out
);

   rme_pkg::cordic_vec_type vec_ff, vec_in_w;
   logic signed [rme_pkg::CW-1:0] dx, dy, ang;

   always_comb begin
      dx  = vec_in.y >>> stage_idx;
      dy  = vec_in.x >>> stage_idx;
      ang = $signed({{(rme_pkg::CW-32){1'b0}}, rme_pkg::ATAN_TABLE[stage_idx]});
      vec_in_w = vec_in;
      // rotate toward y = 0
      if (vec_in.y >= 0) begin
         vec_in_w.x = vec_in.x + dx;
         vec_in_w.y = vec_in.y - dy;
         vec_in_w.z = vec_in.z + ang;
      end else begin
         vec_in_w.x = vec_in.x - dx;
         vec_in_w.y = vec_in.y + dy;
         vec_in_w.z = vec_in.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in_w;
      end
   end

   assign vec_out = vec_ff;

endmodule

@@ design/rme_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined atan2(y, x): quadrant fold, a row of CORDIC cells, rounding to
// Q3.28 with saturation at pi (zero for a zero vector); registered at the fold, in every cell and at the output.
// ----------------------------------------------------------------------------
module rme_cordic (
   input  logic               clock,
   input  logic               en,
   input  logic signed [32:0] y_in,
   input  logic signed [32:0] x_in,
   input  logic               tag_in,
   output logic signed [30:0] angle_out,
   output logic               tag_out
);

   rme_pkg::cordic_vec_type pre_ff, pre_in;
   rme_pkg::cordic_vec_type chain [rme_pkg::CORDIC_STAGES+1];
   logic signed [rme_pkg::CW-1:0] xe, ye, zr, zs;
   logic signed [30:0] angle_ff, angle_in;
   logic               tag_ff;

   always_comb begin
      xe = rme_pkg::CW'(x_in);
      ye = rme_pkg::CW'(y_in);
      pre_in.zero = (x_in == 33'sd0) && (y_in == 33'sd0);
      pre_in.tag  = tag_in;
      pre_in.x    = xe;
      pre_in.y    = ye;
      pre_in.z    = '0;
      // turn a left-half vector by pi
      if (x_in < 0) begin
         pre_in.x = -xe;
         pre_in.y = -ye;
         pre_in.z = (y_in >= 0) ? rme_pkg::PI_Q30 : -rme_pkg::PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_ff <= pre_in;
      end
   end

   assign chain[0] = pre_ff;

   for (genvar i = 0; i < rme_pkg::CORDIC_STAGES; i++) begin : g_cell
      rme_cordic_cell u_cell (
         .clock     (clock),
         .en        (en),
         .stage_idx (5'(i)),
         .vec_in    (chain[i]),
         .vec_out   (chain[i+1])
      );
   end

   always_comb begin
      zr = chain[rme_pkg::CORDIC_STAGES].z + 36'sd2;
      zs = zr >>> 2;
      if (chain[rme_pkg::CORDIC_STAGES].zero) begin
         angle_in = '0;
      end else if (zs > rme_pkg::PI_Q28) begin
         angle_in = rme_pkg::PI_Q28[30:0];
      end else if (zs < -rme_pkg::PI_Q28) begin
         angle_in = -(rme_pkg::PI_Q28[30:0]);
      end else begin
         angle_in = zs[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
         tag_ff   <= chain[rme_pkg::CORDIC_STAGES].tag;
      end
   end

   assign angle_out = angle_ff;
   assign tag_out   = tag_ff;

endmodule

@@ design/rme_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_sqrt_cell
// One result bit of a digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module rme_sqrt_cell (
   input  logic                  clock,
   input  logic                  en,
   input  logic [4:0]            bit_idx,
   input  rme_pkg::sqrt_vec_type vec_in,
   output rme_pkg::sqrt_vec_type vec_out
);

   rme_pkg::sqrt_vec_type vec_ff, vec_in_w;
   logic [rme_pkg::SW-1:0] trial_bit, trial;
   logic [6:0]             shamt;

   always_comb begin
      shamt     = 7'd62 - {1'b0, bit_idx, 1'b0};
      trial_bit = 64'd1 << shamt;
      trial     = vec_in.res + trial_bit;
      vec_in_w  = vec_in;
      if (vec_in.n >= trial) begin
         vec_in_w.n   = vec_in.n - trial;
         vec_in_w.res = (vec_in.res >> 1) + trial_bit;
      end else begin
         vec_in_w.res = vec_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in_w;
      end
   end

   assign vec_out = vec_ff;

endmodule

@@ design/rotation_matrix_to_euler_angles.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles
// Yaw, pitch and bank angles (Y, X, Z order) from a Q2.30 rotation matrix.
// ----------------------------------------------------------------------------
// One matrix is accepted per clock while the output is not stalled; the result
// passes the two input stages, the 32-cell square root chain, the pitch CORDIC
// row behind it and the output register. The whole pipeline advances together,
// so a stalled result holds every stage; empty stages are filled as the output
// is taken. Bank and yaw run through their own CORDIC rows and are delayed to
// meet pitch. The gimbal threshold may be rewritten only while idle.
module rotation_matrix_to_euler_angles (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // m00, m01, m02, m10, m11, m12, m22 (32 bits each, from bit 0)
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // yaw[30:0], pitch[60:31], bank[91:61], zero pad [95:92]
   output logic [95:0]  rsp_tdata,
   // gimbal_locked
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [30:0]  csr_data
);

   logic        adv;
   logic [30:0] thr_ff;
   logic        vld_ff [rme_pkg::OUT_IDX+1];

   logic signed [31:0] m00, m01, m02, m10, m11, m12, m22, m12c;
   logic [30:0]        mag;
   logic               locked;

   logic signed [31:0] s1_s_ff;
   logic [30:0]        s1_mag_ff;
   logic               s1_locked_ff;
   logic signed [32:0] s1_by_ff, s1_bx_ff, s1_yy_ff, s1_yx_ff;

   logic signed [31:0] s2_s_ff;
   logic [61:0]        s2_magsq_ff;

   rme_pkg::sqrt_vec_type sq_chain [rme_pkg::SQRT_CELLS+1];

   logic signed [30:0] bank_a, yaw_a, pitch_a;
   logic               bank_lock;
   logic               yaw_tag_unused;
   logic               pitch_tag_unused;
   logic [62:0]        dly_ff [rme_pkg::BANK_DELAY];

   logic signed [29:0] pitch_sat;
   logic [30:0]        rsp_yaw_ff, rsp_bank_ff;
   logic [29:0]        rsp_pitch_ff;
   logic               rsp_lock_ff;

   assign adv        = !vld_ff[rme_pkg::OUT_IDX] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rme_pkg::GT_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   always_comb begin
      m00 = req_tdata[31:0];
      m01 = req_tdata[63:32];
      m02 = req_tdata[95:64];
      m10 = req_tdata[127:96];
      m11 = req_tdata[159:128];
      m12 = req_tdata[191:160];
      m22 = req_tdata[223:192];
      // clamp to unit magnitude
      if (m12 > rme_pkg::UNIT_Q30) begin
         m12c = rme_pkg::UNIT_Q30;
      end else if (m12 < -rme_pkg::UNIT_Q30) begin
         m12c = -rme_pkg::UNIT_Q30;
      end else begin
         m12c = m12;
      end
      mag    = (m12c < 0) ? 31'(-m12c) : m12c[30:0];
      locked = mag >= thr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= rme_pkg::OUT_IDX; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k <= rme_pkg::OUT_IDX; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_s_ff      <= -m12c;
         s1_mag_ff    <= mag;
         s1_locked_ff <= locked;
         s1_by_ff     <= locked ? -33'(m01) : 33'(m10);
         s1_bx_ff     <= locked ? 33'(m00) : 33'(m11);
         s1_yy_ff     <= 33'(m02);
         s1_yx_ff     <= 33'(m22);
         s2_s_ff      <= s1_s_ff;
         s2_magsq_ff  <= s1_mag_ff * s1_mag_ff;
      end
   end

   // c = floor(sqrt(2^60 - m12^2))
   always_comb begin
      sq_chain[0].n   = (64'd1 << 60) - {2'b00, s2_magsq_ff};
      sq_chain[0].res = '0;
      sq_chain[0].s   = s2_s_ff;
   end

   for (genvar k = 0; k < rme_pkg::SQRT_CELLS; k++) begin : g_sqrt
      rme_sqrt_cell u_cell (
         .clock   (clock),
         .en      (adv),
         .bit_idx (5'(k)),
         .vec_in  (sq_chain[k]),
         .vec_out (sq_chain[k+1])
      );
   end

   rme_cordic u_pitch (
      .clock     (clock),
      .en        (adv),
      .y_in      (33'(sq_chain[rme_pkg::SQRT_CELLS].s)),
      .x_in      ({1'b0, sq_chain[rme_pkg::SQRT_CELLS].res[31:0]}),
      .tag_in    (1'b0),
      .angle_out (pitch_a),
      .tag_out   (pitch_tag_unused)
   );

   rme_cordic u_bank (
      .clock     (clock),
      .en        (adv),
      .y_in      (s1_by_ff),
      .x_in      (s1_bx_ff),
      .tag_in    (s1_locked_ff),
      .angle_out (bank_a),
      .tag_out   (bank_lock)
   );

   rme_cordic u_yaw (
      .clock     (clock),
      .en        (adv),
      .y_in      (s1_yy_ff),
      .x_in      (s1_yx_ff),
      .tag_in    (1'b0),
      .angle_out (yaw_a),
      .tag_out   (yaw_tag_unused)
   );

   // hold bank and yaw until pitch catches up
   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= {bank_lock, bank_a, bank_lock ? 31'd0 : yaw_a};
         for (int k = 1; k < rme_pkg::BANK_DELAY; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   always_comb begin
      if (pitch_a > rme_pkg::HALF_PI_Q28) begin
         pitch_sat = rme_pkg::HALF_PI_Q28[29:0];
      end else if (pitch_a < -rme_pkg::HALF_PI_Q28) begin
         pitch_sat = -(rme_pkg::HALF_PI_Q28[29:0]);
      end else begin
         pitch_sat = pitch_a[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_lock_ff  <= dly_ff[rme_pkg::BANK_DELAY-1][62]
                         | ((yaw_tag_unused | pitch_tag_unused) & 1'b0);
         rsp_bank_ff  <= dly_ff[rme_pkg::BANK_DELAY-1][61:31];
         rsp_yaw_ff   <= dly_ff[rme_pkg::BANK_DELAY-1][30:0];
         rsp_pitch_ff <= pitch_sat;
      end
   end

   assign rsp_tvalid = vld_ff[rme_pkg::OUT_IDX];
   assign rsp_tdata  = {4'b0000, rsp_bank_ff, rsp_pitch_ff, rsp_yaw_ff};
   assign rsp_tuser  = rsp_lock_ff;

`ifndef SYNTHESIS
   a_lock_zero_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[30:0] == 31'd0)
      else $error("yaw not zero at gimbal lock");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[60:31]) <= 30'sd421657428)
                  && ($signed(rsp_tdata[60:31]) >= -30'sd421657428))
      else $error("pitch beyond half pi");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted transaction lost at first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff[rme_pkg::OUT_IDX-1]))
      else $error("pipeline moved during stall");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams random and corner-case matrices through the Euler angle block and
// compares every yaw, pitch, bank and gimbal flag with a bit-exact predictor.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LATENCY = rme_pkg::CORDIC_STAGES + 36;
   localparam longint PI30 = 64'sd3373259426;
   localparam longint PI28 = 64'sd843314857;
   localparam longint HPI28 = 64'sd421657428;
   localparam longint UNIT = 64'sd1073741824;

   typedef struct packed {
      logic signed [31:0] m22, m12, m11, m10, m02, m01, m00;
   } matrix_type;

   typedef struct packed {
      logic [30:0] yaw;
      logic [29:0] pitch;
      logic [30:0] bank;
      logic        locked;
   } angles_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [223:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [30:0]  csr_data = '0;

   rotation_matrix_to_euler_angles u_dut (.*);

   logic [30:0] threshold = rme_pkg::GT_RESET;
   matrix_type  pending_matrices [$];
   angles_type  expected_angles [$];
   int          errors = 0;
   int          matrices_sent = 0;
   int          angles_seen = 0;
   int          locked_seen = 0;
   int          send_wait = 0;
   int          recv_wait = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint cordic_atan2(longint y, longint x);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? PI30 : -PI30;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < rme_pkg::CORDIC_STAGES && i < 32; i++) begin
         dx = shift_floor(y, i);
         dy = shift_floor(x, i);
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += longint'(rme_pkg::ATAN_TABLE[i]);
         end else begin
            x -= dx;
            y += dy;
            z -= longint'(rme_pkg::ATAN_TABLE[i]);
         end
      end
      return clip(shift_floor(z + 2, 2), PI28);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function automatic angles_type predict_angles(matrix_type m);
      angles_type a;
      longint r12;
      longint mag;
      longint c;
      longint yaw;
      longint bank;
      r12 = m.m12;
      if (r12 > UNIT) r12 = UNIT;
      if (r12 < -UNIT) r12 = -UNIT;
      mag = (r12 < 0) ? -r12 : r12;
      a.locked = mag >= longint'(threshold);
      c = longint'(floor_sqrt((64'd1 << 60) - 64'(mag * mag)));
      a.pitch = 30'(clip(cordic_atan2(-r12, c), HPI28));
      if (a.locked) begin
         bank = cordic_atan2(-longint'(m.m01), m.m00);
         yaw = 0;
      end else begin
         bank = cordic_atan2(m.m10, m.m11);
         yaw = cordic_atan2(m.m02, m.m22);
      end
      a.yaw = 31'(yaw);
      a.bank = 31'(bank);
      return a;
   endfunction

   function automatic logic signed [31:0] rand_element();
      case ($urandom_range(0, 9))
         0: return -32'sd1073741824;
         1: return 32'sd1073741824;
         2: return 32'sd0;
         3: return $urandom;
         4: return 32'($urandom_range(0, 64)) - 32'sd32;
         default: return 32'($urandom_range(0, 32'h8000_0000)) - 32'sd1073741824;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_m12();
      case ($urandom_range(0, 7))
         0: return 32'sd1073741824 - 32'($urandom_range(0, 40000));
         1: return -32'sd1073741824 + 32'($urandom_range(0, 40000));
         2: return $urandom;
         default: return rand_element();
      endcase
   endfunction

   // drive matrices; sender gap drawn per transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_angles.push_back(predict_angles(matrix_type'(req_tdata)));
            matrices_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               req_tvalid <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (pending_matrices.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_matrices.pop_front();
               send_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // check results; receiver stall drawn per transaction
   always @(posedge clock) begin
      angles_type got;
      angles_type want;
      int         gap;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[30:0], rsp_tdata[60:31], rsp_tdata[91:61], rsp_tuser[0]};
            angles_seen++;
            if (got.locked) locked_seen++;
            if (expected_angles.size() == 0) begin
               errors++;
               $display("%0t unexpected result: actual %h", $time, got);
            end else begin
               want = expected_angles.pop_front();
               if (got.yaw !== want.yaw) begin
                  errors++;
                  $display("%0t yaw: expected %h actual %h", $time, want.yaw, got.yaw);
               end
               if (got.pitch !== want.pitch) begin
                  errors++;
                  $display("%0t pitch: expected %h actual %h", $time, want.pitch,
                           got.pitch);
               end
               if (got.bank !== want.bank) begin
                  errors++;
                  $display("%0t bank: expected %h actual %h", $time, want.bank, got.bank);
               end
               if (got.locked !== want.locked) begin
                  errors++;
                  $display("%0t locked: expected %b actual %b", $time, want.locked,
                           got.locked);
               end
            end
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
            recv_wait <= gap;
            rsp_tready <= (gap == 0);
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_tready <= (recv_wait == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_threshold(logic [30:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      threshold = value;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_matrices.size() > 0 || req_tvalid || expected_angles.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      matrix_type m;
      for (int i = 0; i < count; i++) begin
         m.m00 = rand_element();
         m.m01 = rand_element();
         m.m02 = rand_element();
         m.m10 = rand_element();
         m.m11 = rand_element();
         m.m12 = rand_m12();
         m.m22 = rand_element();
         pending_matrices.push_back(m);
      end
   endtask

   initial begin
      logic signed [31:0] u;
      logic [30:0] settings [6];
      u = 32'sd1073741824;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: unit diagonal plus m02, its negation, gimbal lock, zero atan2, out-of-range m12
      pending_matrices.push_back('{u, 0, u, 0, u, 0, u});
      pending_matrices.push_back('{-u, 0, -u, 0, -u, 0, -u});
      pending_matrices.push_back('{u, u, 0, u, 0, u, 0});
      pending_matrices.push_back('{u, -u, 0, -u, 0, -u, 0});
      pending_matrices.push_back('{0, 0, 0, 0, 0, 0, 0});
      pending_matrices.push_back('{0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0});
      pending_matrices.push_back('{0, 32'sh8000_0000, 0, 0, 0, 0, 0});
      pending_matrices.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
         32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
      pending_matrices.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
      pending_matrices.push_back('{-u, 0, u, 0, -u, 0, -1});
      pending_matrices.push_back('{0, 0, 0, 1, -1, 0, 0});
      pending_matrices.push_back('{0, 1, 32'sd1073731087, 0, 0, 0, -1});
      pending_matrices.push_back('{0, 1, 32'sd1073731086, 0, 0, 0, -1});
      pending_matrices.push_back('{0, 0, -32'sd1073731087, -1, 0, 0, 0});
      queue_random(200);
      drain();

      settings = '{31'd0, 31'h7FFF_FFFF, 31'd1073741824, 31'd1073741825,
                   31'd536870912, rme_pkg::GT_RESET};
      foreach (settings[k]) begin
         write_threshold(settings[k]);
         queue_random(k == 5 ? 300 : 140);
         drain();
      end
      write_threshold(31'($urandom_range(0, 32'h4000_0000)));
      queue_random(60);
      drain();

      $display("Sent %0d matrices over 8 threshold settings; %0d results, %0d gimbal locked.",
               matrices_sent, angles_seen, locked_seen);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
design/rme_pkg.sv
design/rme_cordic_cell.sv
design/rme_cordic.sv
design/rme_sqrt_cell.sv
design/rotation_matrix_to_euler_angles.sv
tb/testbench.sv
